// File: rtl/core/scpr_pkg.sv
`timescale 1ns / 1ps

package scpr_pkg;

    // Default build constants of the regulator
    localparam int REF_MILLIVOLTS_DEF = 3300;
    localparam int DIVIDER_NUM_DEF    = 2;
    localparam int DIVIDER_DEN_DEF    = 1;
    localparam int SENSE_GAIN_DEF     = 50;
    localparam int MIN_DUTY_DEF       = 1;
    localparam int RECHECK_MS_DEF     = 5000;

    // Fixed arithmetic constants
    localparam int ADC_FULL     = 1023;
    localparam int CUR_SCALE    = 6;
    localparam int DUTY_FULL    = 255;
    localparam int RATE_SHIFT   = 8;
    localparam int DIV_ROUND    = 255;
    localparam int CUR_MAX      = 32767;
    localparam int BOARD_HOT    = 100;
    localparam int BOARD_COLD   = 4;
    localparam int OUTSIDE_COLD = 2;

    // Stream and configuration widths
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 32;
    localparam int CFG_ADDR_W  = 8;
    localparam int CFG_DATA_W  = 16;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_RESPONSE_RATE   = 8'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_COLD_SAFE_MV    = 8'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_COLD_CUR_TARGET = 8'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_TARGET_MV       = 8'd3;

    // Configuration reset values
    localparam logic [15:0] RATE_RST        = 16'd256;
    localparam logic [15:0] COLD_SAFE_RST   = 16'd3700;
    localparam logic [7:0]  COLD_CUR_RST    = 8'd30;
    localparam logic [15:0] TARGET_RST      = 16'd4000;

    // Drive and sleep codes
    localparam logic [1:0] DRIVE_OFF  = 2'd0;
    localparam logic [1:0] DRIVE_FULL = 2'd1;
    localparam logic [1:0] DRIVE_PWM  = 2'd2;
    localparam logic [1:0] SLEEP_SAVE = 2'd0;
    localparam logic [1:0] SLEEP_IDLE = 2'd1;
    localparam logic [1:0] SLEEP_NONE = 2'd2;

    // Microcode word
    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] step_t;
    typedef logic [3:0] op_t;
    typedef logic [1:0] cond_t;

    localparam op_t OP_NOP     = 4'd0;
    localparam op_t OP_MUL_BK  = 4'd1;
    localparam op_t OP_MUL_BM  = 4'd2;
    localparam op_t OP_LD_BATT = 4'd3;
    localparam op_t OP_MUL_VE  = 4'd4;
    localparam op_t OP_LD_VSTP = 4'd5;
    localparam op_t OP_MUL_CK  = 4'd6;
    localparam op_t OP_MUL_CM  = 4'd7;
    localparam op_t OP_LD_CUR  = 4'd8;
    localparam op_t OP_MUL_CE  = 4'd9;
    localparam op_t OP_LD_CAND = 4'd10;
    localparam op_t OP_HOT     = 4'd11;
    localparam op_t OP_FULL    = 4'd12;
    localparam op_t OP_FINISH  = 4'd13;

    localparam cond_t COND_NONE    = 2'd0;
    localparam cond_t COND_ALWAYS  = 2'd1;
    localparam cond_t COND_HOT     = 2'd2;
    localparam cond_t COND_NOCHECK = 2'd3;

    localparam step_t STEP_HOT    = 4'd10;
    localparam step_t STEP_FULL   = 4'd11;
    localparam step_t STEP_FINISH = 4'd12;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ctrl_word_t;

    typedef struct packed {
        logic hot;
        logic nocheck;
    } seq_flags_t;

endpackage

// File: rtl/core/scpr_seq.sv
`timescale 1ns / 1ps

module scpr_seq
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   hold,
    input  scpr_pkg::seq_flags_t   flags,
    output logic                   busy,
    output scpr_pkg::ctrl_word_t   ctrl
);
    import scpr_pkg::*;

    logic       busy_reg;
    logic       busy_next;
    step_t      step_reg;
    step_t      step_next;
    ctrl_word_t rom_out;
    logic       taken;

    // Control program: voltage path, then current check or a hot or full ceiling, then finish
    function automatic ctrl_word_t rom_word(input step_t step);
        ctrl_word_t w;
        w = '{op: OP_FINISH, cond: COND_NONE, target: STEP_FINISH};
        case (step)
            4'd0:  w = '{op: OP_MUL_BK,  cond: COND_NONE,    target: STEP_FINISH};
            4'd1:  w = '{op: OP_MUL_BM,  cond: COND_NONE,    target: STEP_FINISH};
            4'd2:  w = '{op: OP_LD_BATT, cond: COND_NONE,    target: STEP_FINISH};
            4'd3:  w = '{op: OP_MUL_VE,  cond: COND_NONE,    target: STEP_FINISH};
            4'd4:  w = '{op: OP_LD_VSTP, cond: COND_HOT,     target: STEP_HOT};
            4'd5:  w = '{op: OP_MUL_CK,  cond: COND_NOCHECK, target: STEP_FULL};
            4'd6:  w = '{op: OP_MUL_CM,  cond: COND_NONE,    target: STEP_FINISH};
            4'd7:  w = '{op: OP_LD_CUR,  cond: COND_NONE,    target: STEP_FINISH};
            4'd8:  w = '{op: OP_MUL_CE,  cond: COND_NONE,    target: STEP_FINISH};
            4'd9:  w = '{op: OP_LD_CAND, cond: COND_ALWAYS,  target: STEP_FINISH};
            4'd10: w = '{op: OP_HOT,     cond: COND_ALWAYS,  target: STEP_FINISH};
            4'd11: w = '{op: OP_FULL,    cond: COND_NONE,    target: STEP_FINISH};
            default: w = '{op: OP_FINISH, cond: COND_NONE,   target: STEP_FINISH};
        endcase
        return w;
    endfunction

    assign rom_out = rom_word(step_reg);
    assign ctrl    = busy_reg ? rom_out
                              : ctrl_word_t'{op: OP_NOP, cond: COND_NONE, target: STEP_FINISH};
    assign busy    = busy_reg;

    // Evaluate the jump condition of the current word
    always_comb
    begin
        case (rom_out.cond)
            COND_ALWAYS:  taken = 1'b1;
            COND_HOT:     taken = flags.hot;
            COND_NOCHECK: taken = flags.nocheck;
            default:      taken = 1'b0;
        endcase
    end

    // Advance the step counter, jump, or stop at the finish word
    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (!busy_reg)
        begin
            if (start)
            begin
                busy_next = 1'b1;
                step_next = '0;
            end
        end
        else if (!hold)
        begin
            if (rom_out.op == OP_FINISH)
                busy_next = 1'b0;
            else if (taken)
                step_next = rom_out.target;
            else
                step_next = step_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

endmodule

// File: rtl/core/solar_charge_pwm_regulator_top.sv
`timescale 1ns / 1ps
// A result follows each input transfer through the microcode program: the voltage path, then
// the current measurement, skipped when no sensor check is due or when the board is hot.
// A new item is taken only once the program of the last one has finished; the program runs every
// multiply of the item through one shared multiplier, one step per cycle; an unclaimed
// result holds the program at its finish step until the transfer.
// Reset (async, active low) restores the register defaults, a full duty of 255, sensor off.

module solar_charge_pwm_regulator_top
#(
    parameter int REF_MILLIVOLTS = scpr_pkg::REF_MILLIVOLTS_DEF,
    parameter int DIVIDER_NUM    = scpr_pkg::DIVIDER_NUM_DEF,
    parameter int DIVIDER_DEN    = scpr_pkg::DIVIDER_DEN_DEF,
    parameter int SENSE_GAIN     = scpr_pkg::SENSE_GAIN_DEF,
    parameter int MIN_DUTY       = scpr_pkg::MIN_DUTY_DEF,
    parameter int RECHECK_MS     = scpr_pkg::RECHECK_MS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    // slave stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // battery_sample[9:0], current_sample[19:10], board_temp_half_deg[28:20],
    // outside_temp_deg[36:29], now_ms[52:37], zero fill [55:53]
    input  logic [scpr_pkg::IN_TDATA_W-1:0]   s_tdata,
    // master stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // duty_level[7:0], drive_mode[9:8], sleep_mode[11:10], sensor_power[12],
    // current_x6[27:13], zero fill [31:28]
    output logic [scpr_pkg::OUT_TDATA_W-1:0]  m_tdata,
    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [scpr_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [scpr_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import scpr_pkg::*;

    // Constant division by reciprocal: q = (x * M) >> S, exact for x < 2^XW
    localparam longint BATT_K  = longint'(REF_MILLIVOLTS) * longint'(DIVIDER_NUM);
    localparam longint BATT_D  = longint'(DIVIDER_DEN) * longint'(ADC_FULL);
    localparam int     BATT_XW = $clog2(longint'(ADC_FULL) * BATT_K + 1);
    localparam int     BATT_S  = BATT_XW + $clog2(BATT_D);
    localparam longint BATT_M  = ((longint'(1) << BATT_S) + BATT_D - 1) / BATT_D;
    localparam int     BMV_W   = $clog2(longint'(ADC_FULL) * BATT_K / BATT_D + 1);
    localparam int     MV_W    = (BMV_W > CFG_DATA_W) ? BMV_W : CFG_DATA_W;

    localparam longint CUR_K   = longint'(REF_MILLIVOLTS) * longint'(CUR_SCALE);
    localparam longint CUR_D   = longint'(SENSE_GAIN) * longint'(ADC_FULL);
    localparam int     CUR_XW  = $clog2(longint'(ADC_FULL) * CUR_K + 1);
    localparam int     CUR_S   = CUR_XW + $clog2(CUR_D);
    localparam longint CUR_M   = ((longint'(1) << CUR_S) + CUR_D - 1) / CUR_D;

    localparam int ERR_W   = CFG_DATA_W + 1;
    localparam int XW_MAX  = (BATT_XW > CUR_XW) ? BATT_XW : CUR_XW;
    localparam int MUL_W0  = (XW_MAX > MV_W) ? XW_MAX : MV_W;
    localparam int MUL_W   = ((MUL_W0 > ERR_W) ? MUL_W0 : ERR_W) + 2;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int SUM_W   = PROD_W - RATE_SHIFT;

    localparam logic [15:0] RECHECK_T  = 16'(RECHECK_MS);
    localparam logic [7:0]  MIN_DUTY_T = 8'(MIN_DUTY);

    // Configuration registers
    logic [15:0] rate_reg;
    logic [15:0] cold_safe_reg;
    logic [7:0]  cold_cur_reg;
    logic [15:0] target_reg;

    // Captured input item
    logic [9:0]        bsample_reg;
    logic [9:0]        csample_reg;
    logic signed [8:0] board_reg;
    logic signed [7:0] outside_reg;
    logic [15:0]       now_reg;

    // Regulator state
    logic [7:0]  duty_reg;
    logic        sensor_reg;
    logic [15:0] last_check_reg;
    logic [14:0] cur_store_reg;

    // Datapath work registers
    logic signed [PROD_W-1:0] prod_reg;
    logic [MV_W-1:0]          batt_reg;
    logic signed [SUM_W-1:0]  vstep_reg;
    logic [7:0]               ceil_reg;

    // Result register
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [7:0]  out_duty_reg;
    logic [1:0]  out_drive_reg;
    logic [1:0]  out_sleep_reg;
    logic        out_sensor_reg;
    logic [14:0] out_cur_reg;

    // Sequencer link
    logic       busy;
    logic       hold;
    logic       finish_fire;
    logic       in_xfer;
    seq_flags_t flags;
    ctrl_word_t ctrl;

    // Datapath nets
    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic                     mul_en;
    logic signed [PROD_W-1:0] prod_full;
    logic signed [PROD_W-1:0] prod_adj;
    logic [PROD_W-1:0]        batt_q;
    logic [PROD_W-1:0]        cur_q;
    logic [14:0]              cur_sat;
    logic signed [SUM_W-1:0]  step_val;
    logic signed [SUM_W-1:0]  cand;
    logic                     cand_full;
    logic [7:0]               cand_clip;
    logic [10:0]              cur_tgt6;
    logic                     limit;
    logic [15:0]              elapsed;
    logic signed [SUM_W-1:0]  nv_raw;
    logic signed [SUM_W-1:0]  ceil_ext;
    logic [7:0]               nv;
    logic                     can_idle;
    logic [1:0]               drive;
    logic [1:0]               sleep_code;

    assign cfg_ready = 1'b1;
    assign s_tready  = !busy;
    assign in_xfer   = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {4'b0000, out_cur_reg, out_sensor_reg, out_sleep_reg,
                        out_drive_reg, out_duty_reg};

    // Hold at the finish word while the previous result is still unclaimed
    assign hold        = (ctrl.op == OP_FINISH) && out_valid_reg && !m_tready;
    assign finish_fire = (ctrl.op == OP_FINISH) && !hold;

    // Branch flags
    assign elapsed       = now_reg - last_check_reg;
    assign flags.hot     = board_reg > 9'(BOARD_HOT);
    assign flags.nocheck = !sensor_reg && (elapsed <= RECHECK_T);
    assign limit         = (batt_reg > MV_W'(cold_safe_reg)) &&
                           ((board_reg < 0) ||
                            ((board_reg < 9'(BOARD_COLD)) && (outside_reg < 8'(OUTSIDE_COLD))));

    scpr_seq u_seq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (in_xfer),
        .hold  (hold),
        .flags (flags),
        .busy  (busy),
        .ctrl  (ctrl)
    );

    // Six times the cold current target, by shift and add
    assign cur_tgt6 = {1'b0, cold_cur_reg, 2'b00} + {2'b00, cold_cur_reg, 1'b0};

    // Select multiplier operands for the current step
    always_comb
    begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b1;
        case (ctrl.op)
            OP_MUL_BK:
            begin
                mul_a = MUL_W'($signed({1'b0, bsample_reg}));
                mul_b = MUL_W'(BATT_K);
            end
            OP_MUL_BM:
            begin
                mul_a = $signed(prod_reg[MUL_W-1:0]);
                mul_b = MUL_W'(BATT_M);
            end
            OP_MUL_VE:
            begin
                mul_a = MUL_W'($signed({1'b0, target_reg})) - MUL_W'($signed({1'b0, batt_reg}));
                mul_b = MUL_W'($signed({1'b0, rate_reg}));
            end
            OP_MUL_CK:
            begin
                mul_a = MUL_W'($signed({1'b0, csample_reg}));
                mul_b = MUL_W'(CUR_K);
            end
            OP_MUL_CM:
            begin
                mul_a = $signed(prod_reg[MUL_W-1:0]);
                mul_b = MUL_W'(CUR_M);
            end
            OP_MUL_CE:
            begin
                mul_a = MUL_W'($signed({1'b0, cur_tgt6})) -
                        MUL_W'($signed({1'b0, cur_store_reg}));
                mul_b = MUL_W'($signed({1'b0, rate_reg}));
            end
            default:
                mul_en = 1'b0;
        endcase
    end

    assign prod_full = mul_a * mul_b;

    // Quotients of the reciprocal products
    assign batt_q  = prod_reg >> BATT_S;
    assign cur_q   = prod_reg >> CUR_S;
    assign cur_sat = (cur_q > PROD_W'(CUR_MAX)) ? 15'(CUR_MAX) : cur_q[14:0];

    // Divide the rate product by 256, rounding toward zero
    assign prod_adj = prod_reg[PROD_W-1] ? (prod_reg + PROD_W'(DIV_ROUND)) : prod_reg;
    assign step_val = SUM_W'(prod_adj >>> RATE_SHIFT);

    // Candidate ceiling under cold current limiting
    assign cand      = step_val + SUM_W'($signed({1'b0, duty_reg}));
    assign cand_full = !limit || (cand >= SUM_W'(DUTY_FULL));
    assign cand_clip = (cand < 0) ? 8'd0 : cand[7:0];

    // Clamp the stepped duty and pick drive and sleep modes
    assign nv_raw   = vstep_reg + SUM_W'($signed({1'b0, duty_reg}));
    assign ceil_ext = SUM_W'($signed({1'b0, ceil_reg}));

    always_comb
    begin
        if (nv_raw <= 0)
        begin
            nv       = 8'd0;
            can_idle = 1'b1;
        end
        else if (nv_raw >= ceil_ext)
        begin
            nv       = ceil_reg;
            can_idle = 1'b1;
        end
        else
        begin
            nv       = nv_raw[7:0];
            can_idle = 1'b0;
        end

        if (nv < MIN_DUTY_T)
        begin
            drive      = DRIVE_OFF;
            sleep_code = SLEEP_SAVE;
        end
        else if (nv == 8'(DUTY_FULL))
        begin
            drive      = DRIVE_FULL;
            sleep_code = SLEEP_SAVE;
        end
        else
        begin
            drive      = DRIVE_PWM;
            sleep_code = can_idle ? SLEEP_IDLE : SLEEP_NONE;
        end
    end

    // Take configuration writes; unknown indexes drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg      <= RATE_RST;
            cold_safe_reg <= COLD_SAFE_RST;
            cold_cur_reg  <= COLD_CUR_RST;
            target_reg    <= TARGET_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_addr)
                REG_RESPONSE_RATE:   rate_reg      <= cfg_data;
                REG_COLD_SAFE_MV:    cold_safe_reg <= cfg_data;
                REG_COLD_CUR_TARGET: cold_cur_reg  <= cfg_data[7:0];
                REG_TARGET_MV:       target_reg    <= cfg_data;
                default:             ;
            endcase
        end
    end

    // Capture the input item on transfer
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            bsample_reg <= s_tdata[9:0];
            csample_reg <= s_tdata[19:10];
            board_reg   <= $signed(s_tdata[28:20]);
            outside_reg <= $signed(s_tdata[36:29]);
            now_reg     <= s_tdata[52:37];
        end
    end

    // Datapath work registers
    always_ff @(posedge clk)
    begin
        if (mul_en)
            prod_reg <= prod_full;
        case (ctrl.op)
            OP_LD_BATT: batt_reg  <= batt_q[MV_W-1:0];
            OP_LD_VSTP: vstep_reg <= step_val;
            OP_LD_CAND: ceil_reg  <= cand_full ? 8'(DUTY_FULL) : cand_clip;
            OP_HOT:     ceil_reg  <= 8'd0;
            OP_FULL:    ceil_reg  <= 8'(DUTY_FULL);
            default:    ;
        endcase
    end

    // Regulator state updates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duty_reg       <= 8'(DUTY_FULL);
            sensor_reg     <= 1'b0;
            last_check_reg <= '0;
            cur_store_reg  <= '0;
        end
        else
        begin
            case (ctrl.op)
                OP_LD_CUR:
                begin
                    cur_store_reg  <= cur_sat;
                    last_check_reg <= now_reg;
                    sensor_reg     <= 1'b1;
                end
                OP_LD_CAND:
                    sensor_reg <= !cand_full;
                OP_HOT:
                begin
                    sensor_reg    <= 1'b0;
                    cur_store_reg <= '0;
                end
                default: ;
            endcase
            if (finish_fire)
                duty_reg <= nv;
        end
    end

    // Result register
    always_comb
    begin
        if (finish_fire)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (finish_fire)
        begin
            out_duty_reg   <= nv;
            out_drive_reg  <= drive;
            out_sleep_reg  <= sleep_code;
            out_sensor_reg <= sensor_reg;
            out_cur_reg    <= cur_store_reg;
        end
    end

    // A transfer starts the program at its first multiply
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (ctrl.op == OP_MUL_BK))
        else $error("program did not start after input transfer");

    // A hot board ends with the switch off, the sensor off and no current
    a_hot: assert property (@(posedge clk) disable iff (!rst_n)
        (finish_fire && flags.hot) |=> (out_duty_reg == 8'd0 && out_drive_reg == DRIVE_OFF &&
                                        !out_sensor_reg && out_cur_reg == 15'd0))
        else $error("hot board result not forced off");

    // The kept duty never exceeds the ceiling of its item
    a_ceiling: assert property (@(posedge clk) disable iff (!rst_n)
        finish_fire |=> (duty_reg <= ceil_reg))
        else $error("duty above ceiling");

    // Only PWM drive leaves the sleep mode above power save
    a_sleep: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((out_drive_reg == DRIVE_PWM) == (out_sleep_reg != SLEEP_SAVE)))
        else $error("sleep mode inconsistent with drive mode");

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import scpr_pkg::*;

    localparam int QUIET_LIMIT        = 2000;
    localparam int MISMATCH_PRINT_CAP = 40;
    localparam int SETTLE_CYCLES      = 20;
    // an index outside the register map, the block must drop it
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE = 8'd9;

    typedef struct {
        logic [9:0]        battery;
        logic [9:0]        current;
        logic signed [8:0] board;
        logic signed [7:0] outside;
        logic [15:0]       now_ms;
    } charge_tick_t;

    typedef struct {
        logic [7:0]  duty;
        logic [1:0]  drive;
        logic [1:0]  sleep;
        logic        sensor;
        logic [14:0] current;
    } duty_report_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_ADDR_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // regulator state as the testbench tracks it
    logic [15:0] loop_gain;
    logic [15:0] cold_safe_mv;
    logic [7:0]  cold_limit_ma;
    logic [15:0] charge_target_mv;
    logic [7:0]  duty_kept;
    logic        sensor_live;
    logic [15:0] last_check_ms;
    logic [14:0] current_kept;

    duty_report_t pending_duty_reports[$];

    logic [15:0] clock_ms = 16'd0;
    int in_gap_pct    = 0;
    int out_stall_pct = 0;
    int stall_left    = 0;
    int quiet_cycles  = 0;

    int ticks_sent      = 0;
    int reports_seen    = 0;
    int reg_writes      = 0;
    int hot_ticks       = 0;
    int limited_ticks   = 0;
    int skipped_checks  = 0;
    int drive_off_seen  = 0;
    int drive_full_seen = 0;
    int drive_pwm_seen  = 0;
    int mismatch_count  = 0;
    int stray_reports   = 0;

    solar_charge_pwm_regulator_top uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Prediction
    // ---------------------------------------------------------------

    function automatic longint rate_scaled(input longint err);
        return (err * longint'(loop_gain)) / (longint'(1) << RATE_SHIFT);
    endfunction

    // Work out the report for one tick and advance the tracked state
    function automatic duty_report_t regulate_tick(input charge_tick_t t);
        longint       batt_mv;
        longint       board;
        longint       outside;
        longint       cur;
        longint       cand;
        longint       ceil_v;
        longint       nv;
        logic         cold_limit;
        logic         can_idle;
        logic [15:0]  since_check;
        duty_report_t r;

        batt_mv = (longint'(t.battery) * REF_MILLIVOLTS_DEF * DIVIDER_NUM_DEF)
                  / (DIVIDER_DEN_DEF * ADC_FULL);
        board   = longint'(t.board);
        outside = longint'(t.outside);

        // PWM ceiling from temperature and the current check
        if (board > BOARD_HOT)
        begin
            sensor_live  = 1'b0;
            current_kept = '0;
            ceil_v       = 0;
            hot_ticks++;
        end
        else
        begin
            cold_limit = (batt_mv > longint'(cold_safe_mv)) &&
                         (board < 0 || (board < BOARD_COLD && outside < OUTSIDE_COLD));
            since_check = t.now_ms - last_check_ms;
            if (!sensor_live && since_check <= RECHECK_MS_DEF)
            begin
                ceil_v = DUTY_FULL;
                skipped_checks++;
            end
            else
            begin
                sensor_live = 1'b1;
                cur = (longint'(t.current) * REF_MILLIVOLTS_DEF * CUR_SCALE)
                      / (SENSE_GAIN_DEF * ADC_FULL);
                if (cur > CUR_MAX)
                    cur = CUR_MAX;
                current_kept  = cur[14:0];
                last_check_ms = t.now_ms;
                cand = longint'(duty_kept) +
                       rate_scaled(longint'(cold_limit_ma) * CUR_SCALE - cur);
                if (!cold_limit || cand >= DUTY_FULL)
                begin
                    sensor_live = 1'b0;
                    ceil_v      = DUTY_FULL;
                end
                else
                begin
                    ceil_v = (cand < 0) ? 0 : cand;
                    limited_ticks++;
                end
            end
        end

        // step the duty by the voltage error and clamp it
        nv = longint'(duty_kept) + rate_scaled(longint'(charge_target_mv) - batt_mv);
        can_idle = 1'b1;
        if (nv <= 0)
            nv = 0;
        else if (nv >= ceil_v)
            nv = ceil_v;
        else
            can_idle = 1'b0;

        if (nv < MIN_DUTY_DEF)
        begin
            r.drive = DRIVE_OFF;
            r.sleep = SLEEP_SAVE;
            drive_off_seen++;
        end
        else if (nv >= DUTY_FULL)
        begin
            nv      = DUTY_FULL;
            r.drive = DRIVE_FULL;
            r.sleep = SLEEP_SAVE;
            drive_full_seen++;
        end
        else
        begin
            r.drive = DRIVE_PWM;
            r.sleep = can_idle ? SLEEP_IDLE : SLEEP_NONE;
            drive_pwm_seen++;
        end

        duty_kept = nv[7:0];
        r.duty    = duty_kept;
        r.sensor  = sensor_live;
        r.current = current_kept;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    function automatic charge_tick_t tick_of(input int b, input int c, input int bd,
                                             input int o, input int n);
        charge_tick_t t;
        t.battery = b[9:0];
        t.current = c[9:0];
        t.board   = bd[8:0];
        t.outside = o[7:0];
        t.now_ms  = n[15:0];
        return t;
    endfunction

    // Mostly a steadily advancing clock near the charge thresholds, some noise
    function automatic charge_tick_t random_tick();
        charge_tick_t t;
        int pick;
        int v;

        pick = $urandom_range(0, 99);
        if (pick < 80)
            clock_ms = clock_ms + 16'($urandom_range(1, 2600));
        else if (pick < 90)
            clock_ms = clock_ms + 16'($urandom_range(4990, 5010));
        else if (pick >= 95)
            clock_ms = 16'($urandom);
        t.now_ms = clock_ms;

        t.battery = ($urandom_range(0, 3) != 0) ? 10'($urandom_range(540, 680))
                                                : 10'($urandom_range(0, 1023));
        t.current = ($urandom_range(0, 9) < 3) ? 10'($urandom_range(0, 150))
                                               : 10'($urandom_range(0, 1023));

        pick = $urandom_range(0, 99);
        if (pick < 60)
            v = $urandom_range(0, 30) - 15;
        else if (pick < 85)
            v = $urandom_range(0, 410) - 160;
        else
            v = $urandom_range(95, 106);
        t.board = v[8:0];

        v = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 10) - 5
                                        : $urandom_range(0, 205) - 80;
        t.outside = v[7:0];
        return t;
    endfunction

    // Offer one tick and predict its report once it is taken
    task automatic send_tick(input charge_tick_t t);
        int gap;

        gap = (in_gap_pct != 0 && $urandom_range(0, 99) < in_gap_pct)
              ? $urandom_range(1, 14) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, t.now_ms, t.outside, t.board, t.current, t.battery};
        do
            @(posedge clk);
        while (!s_tready);
        pending_duty_reports.push_back(regulate_tick(t));
        ticks_sent++;
    endtask

    // Hold the input side until every predicted report has come out
    task automatic wait_reports_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_duty_reports.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_RESPONSE_RATE:   loop_gain        = val;
            REG_COLD_SAFE_MV:    cold_safe_mv     = val;
            REG_COLD_CUR_TARGET: cold_limit_ma    = val[7:0];
            REG_TARGET_MV:       charge_target_mv = val;
            default: ;
        endcase
        reg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_all_regs(input logic [15:0] gain, input logic [15:0] safe_mv,
                                  input logic [15:0] limit_ma, input logic [15:0] target);
        write_reg(REG_RESPONSE_RATE, gain);
        write_reg(REG_COLD_SAFE_MV, safe_mv);
        write_reg(REG_COLD_CUR_TARGET, limit_ma);
        write_reg(REG_TARGET_MV, target);
    endtask

    // ---------------------------------------------------------------
    // Result checking
    // ---------------------------------------------------------------

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            mismatch_count++;
            if (mismatch_count <= MISMATCH_PRINT_CAP)
                $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : report_check
        duty_report_t want;
        duty_report_t got;

        if (rst_n && m_tvalid && m_tready)
        begin
            got.duty    = m_tdata[7:0];
            got.drive   = m_tdata[9:8];
            got.sleep   = m_tdata[11:10];
            got.sensor  = m_tdata[12];
            got.current = m_tdata[27:13];
            if (pending_duty_reports.size() == 0)
            begin
                stray_reports++;
                $display("%0t ns: report with none expected, actual tdata %h",
                         $time, m_tdata);
            end
            else
            begin
                want = pending_duty_reports.pop_front();
                check_field("duty_level", want.duty, got.duty);
                check_field("drive_mode", want.drive, got.drive);
                check_field("sleep_mode", want.sleep, got.sleep);
                check_field("sensor_power", want.sensor, got.sensor);
                check_field("current_x6", want.current, got.current);
            end
            reports_seen++;
        end
    end

    // Random backpressure on the report side, in bursts
    always @(negedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if (out_stall_pct != 0 && $urandom_range(0, 99) < out_stall_pct)
        begin
            stall_left <= $urandom_range(0, 13);
            m_tready   <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // Abort when nothing moves on any channel for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t ns: no transfer for %0d cycles, %0d reports outstanding",
                     $time, quiet_cycles, pending_duty_reports.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Field extremes and each branch of the ceiling logic at reset settings
    task automatic test_directed_corners();
        in_gap_pct    = 20;
        out_stall_pct = 20;
        send_tick(tick_of(0, 0, 20, 20, 0));              // full drive
        send_tick(tick_of(1023, 1023, -160, -80, 100));   // error drives duty to zero
        send_tick(tick_of(615, 0, 40, 30, 200));          // pwm, no sleep
        send_tick(tick_of(600, 300, -1, 10, 5301));       // cold limit, clamp to ceiling
        send_tick(tick_of(600, 300, -1, 10, 5302));       // sensor kept on, measure again
        send_tick(tick_of(600, 1023, 3, 1, 5400));        // negative candidate
        send_tick(tick_of(600, 0, 3, 2, 5500));           // outside too warm to limit
        send_tick(tick_of(600, 0, 4, -80, 11000));        // board too warm to limit
        send_tick(tick_of(700, 500, 101, 0, 11100));      // hot board
        send_tick(tick_of(700, 500, 100, 0, 11200));      // just below hot
        send_tick(tick_of(1023, 0, 250, 125, 65535));     // hottest, max time
        send_tick(tick_of(615, 200, 10, 10, 16000));      // recheck interval exactly
        send_tick(tick_of(615, 200, 10, 10, 16001));      // one past recheck interval
        send_tick(tick_of(615, 200, 10, 10, 65000));
        send_tick(tick_of(615, 200, 10, 10, 3464));       // time wrapped, skip check
        send_tick(tick_of(615, 200, 10, 10, 4465));       // time wrapped, check due
        send_tick(tick_of(1023, 1023, -1, -1, 9500));     // max current while cold
        send_tick(tick_of(0, 0, -160, 125, 9600));
        send_tick(tick_of(620, 0, 0, 0, 9700));           // zero voltage error
        send_tick(tick_of(574, 1, -1, 1, 20000));         // just above cold threshold
        send_tick(tick_of(573, 1022, -1, 1, 26000));      // just below cold threshold
        clock_ms = 16'd26000;
    endtask

    // Registers at their limits, with random ticks under each setting
    task automatic test_register_extremes();
        int n;
        int s;

        in_gap_pct    = 15;
        out_stall_pct = 15;
        for (s = 0; s < 5; s++)
        begin
            wait_reports_drained();
            case (s)
                0: write_all_regs(16'd0, 16'd0, 16'hFFFF, 16'd0);
                1: write_all_regs(16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF);
                2: write_all_regs(16'd1, COLD_SAFE_RST, 16'd255, TARGET_RST);
                3: write_all_regs(16'hFFFF, 16'd0, 16'd0, 16'd0);
                default:
                begin
                    write_reg(REG_SPARE, 16'($urandom));
                    write_all_regs(RATE_RST, COLD_SAFE_RST, 16'(COLD_CUR_RST), TARGET_RST);
                    write_reg(REG_SPARE, 16'hFFFF);
                end
            endcase
            for (n = 0; n < 30; n++)
                send_tick(random_tick());
        end
    endtask

    // Long random regulation runs under changing settings and idling
    task automatic test_random_regulation();
        int phase;
        int n;

        for (phase = 0; phase < 6; phase++)
        begin
            wait_reports_drained();
            write_reg(REG_RESPONSE_RATE, ($urandom_range(0, 3) == 0)
                      ? 16'($urandom) : 16'($urandom_range(16, 768)));
            write_reg(REG_COLD_SAFE_MV, ($urandom_range(0, 3) == 0)
                      ? 16'($urandom) : 16'($urandom_range(3300, 4300)));
            write_reg(REG_COLD_CUR_TARGET, 16'($urandom));
            write_reg(REG_TARGET_MV, ($urandom_range(0, 3) == 0)
                      ? 16'($urandom) : 16'($urandom_range(3500, 4600)));
            if ($urandom_range(0, 2) == 0)
                write_reg(REG_SPARE, 16'($urandom));
            in_gap_pct    = (phase % 3) * 15;
            out_stall_pct = ((phase + 1) % 3) * 15;
            for (n = 0; n < 140; n++)
            begin
                // let the block run dry once in the middle of a phase
                if (phase == 2 && n == 70)
                    wait_reports_drained();
                send_tick(random_tick());
            end
        end
    endtask

    // Back-to-back traffic with no idling at all
    task automatic test_steady_finish();
        int n;

        in_gap_pct    = 0;
        out_stall_pct = 0;
        for (n = 0; n < 60; n++)
            send_tick(random_tick());
    endtask

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_addr  = '0;
        cfg_data  = '0;

        loop_gain        = RATE_RST;
        cold_safe_mv     = COLD_SAFE_RST;
        cold_limit_ma    = COLD_CUR_RST;
        charge_target_mv = TARGET_RST;
        duty_kept        = 8'(DUTY_FULL);
        sensor_live      = 1'b0;
        last_check_ms    = '0;
        current_kept     = '0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_corners();
        test_register_extremes();
        test_random_regulation();
        test_steady_finish();

        // drain, then give the block time to show any stray report
        wait_reports_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Ran %0d ticks, %0d reports, %0d register writes; %0d hot, %0d cold-limited,",
                 ticks_sent, reports_seen, reg_writes, hot_ticks, limited_ticks);
        $display("%0d sensor checks skipped; drive off %0d, full %0d, pwm %0d; %0d mismatches",
                 skipped_checks, drive_off_seen, drive_full_seen, drive_pwm_seen,
                 mismatch_count + stray_reports);
        if (mismatch_count == 0 && stray_reports == 0 && pending_duty_reports.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/scpr_pkg.sv
rtl/core/scpr_seq.sv
rtl/core/solar_charge_pwm_regulator_top.sv
test/tb_top.sv
